@@ rtl/gltc_pkg.sv @@
// Shared types, codes and helper functions of the gate lap timer controller.
`timescale 1ns / 1ps

package gltc_pkg;

    // Command codes carried by an input transaction.
    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_GATE = 2'd1,
        CMD_POLL = 2'd2,
        CMD_LOAD = 2'd3
    } t_cmd;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_LOCKOUT    = 2'd0,
        CFG_LONG_PRESS = 2'd1,
        CFG_DEBOUNCE   = 2'd2,
        CFG_MIN_RECORD = 2'd3
    } t_cfg_idx;

    // Timer phase, one-hot.
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RUN  = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    // Encoded run state on the result port.
    localparam logic [1:0] RUN_IDLE     = 2'd0;
    localparam logic [1:0] RUN_RUNNING  = 2'd1;
    localparam logic [1:0] RUN_FINISHED = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] LOCKOUT_RST    = 16'd1000;
    localparam logic [15:0] LONG_PRESS_RST = 16'd2000;
    localparam logic [9:0]  DEBOUNCE_RST   = 10'd50;
    localparam logic [31:0] MIN_RECORD_RST = 32'd100000;

    // Storage value that marks an empty best time.
    localparam logic [31:0] EMPTY_STORE = 32'hFFFF_FFFF;

    // Digit limits of the mixed-radix tick representation.
    localparam logic [6:0] UNIT_MAX    = 7'd99;
    localparam logic [9:0] MS_MAX      = 10'd999;
    localparam logic [5:0] SEC_MAX     = 6'd59;
    localparam logic [6:0] MIN_MOD_MAX = 7'd98;
    localparam logic [6:0] HIGH_CAP    = 7'd99;

    // A tick count held as minutes, seconds, milliseconds and 10 us units,
    // plus the minutes modulo 99 for the minute display.
    typedef struct packed {
        logic [9:0] mins;
        logic [6:0] mins_mod;
        logic [5:0] secs;
        logic [9:0] msecs;
        logic [6:0] units;
    } t_digits;

    // Advance a digit set by one tick with carries between the fields.
    function automatic t_digits digits_inc(input t_digits d);
        t_digits r;
        r = d;
        if (d.units != UNIT_MAX) begin
            r.units = d.units + 7'd1;
        end else begin
            r.units = '0;
            if (d.msecs != MS_MAX) begin
                r.msecs = d.msecs + 10'd1;
            end else begin
                r.msecs = '0;
                if (d.secs != SEC_MAX) begin
                    r.secs = d.secs + 6'd1;
                end else begin
                    r.secs     = '0;
                    r.mins     = d.mins + 10'd1;
                    r.mins_mod = (d.mins_mod == MIN_MOD_MAX) ? 7'd0 : d.mins_mod + 7'd1;
                end
            end
        end
        return r;
    endfunction

    // Whole seconds of a digit set, saturated at 99.
    function automatic logic [6:0] fine_high(input t_digits d);
        logic [6:0] sum;
        sum = (d.mins[0] ? 7'd60 : 7'd0) + {1'b0, d.secs};
        if (d.mins > 10'd1 || sum > HIGH_CAP) begin
            return HIGH_CAP;
        end
        return sum;
    endfunction

endpackage

@@ rtl/gate_lap_timer_controller.sv @@
// Top level of the gate lap timer controller: timing, best time and digit output.
`timescale 1ns / 1ps

// Gate lap timer controller. Each input transaction (10 us tick, gate trigger,
// button poll or best-time load) yields exactly one result transaction with the
// run state, display digits, best time and any save request. An item is taken
// into an input register, then handled by the combinational update stage,
// whose outcome lands in the result register; one item is taken every cycle
// when the result side does not stall. The single update stage sets the rate;
// the display digits are kept as running minute, second, millisecond and 10 us
// counters next to the tick count, so no divider sits in the path. While the
// result register is held, the input register can still take one more
// transaction.
module gate_lap_timer_controller
    import gltc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port.
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_now_ms,
    input  logic        i_reset_pressed,
    input  logic        i_mode_pressed,
    input  logic [31:0] i_stored_best,
    // Result channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_run_state,
    output logic        o_fine_mode,
    output logic [6:0]  o_digits_high,
    output logic [9:0]  o_digits_middle,
    output logic [9:0]  o_digits_low,
    output logic [31:0] o_best_ticks_out,
    output logic        o_save_request,
    output logic [31:0] o_save_value
);

    // Configuration registers.
    logic [15:0] r_lockout;
    logic [15:0] r_long_press;
    logic [9:0]  r_debounce;
    logic [31:0] r_min_record;

    // Input register.
    logic        r_in_valid;
    t_cmd        r_in_cmd;
    logic [31:0] r_in_now;
    logic        r_in_rst_btn;
    logic        r_in_mode_btn;
    logic [31:0] r_in_stored;

    // Timer state.
    t_phase      r_phase,         n_phase;
    logic [31:0] r_tick,          n_tick;
    t_digits     r_tick_dig,      n_tick_dig;
    logic [31:0] r_captured,      n_captured;
    t_digits     r_cap_dig,       n_cap_dig;
    logic [31:0] r_last_trig,     n_last_trig;
    logic [31:0] r_best,          n_best;
    logic [31:0] r_last_seen,     n_last_seen;
    logic        r_rec_checked,   n_rec_checked;
    logic [31:0] r_rst_hold,      n_rst_hold;
    logic        r_rst_handled,   n_rst_handled;
    logic        r_mode_was,      n_mode_was;
    logic [31:0] r_mode_hold,     n_mode_hold;
    logic        r_fine,          n_fine;

    // Result register.
    logic        r_out_valid;
    logic [1:0]  r_out_run_state;
    logic        r_out_fine;
    logic [6:0]  r_out_high;
    logic [9:0]  r_out_middle;
    logic [9:0]  r_out_low;
    logic [31:0] r_out_best;
    logic        r_out_save;
    logic [31:0] r_out_save_val;

    // Update stage outcome.
    logic        w_advance;
    logic        w_save;
    logic [31:0] w_save_val;
    logic [1:0]  w_run_state;
    t_digits     w_shown;
    logic [6:0]  w_high;
    logic [9:0]  w_middle;
    logic [9:0]  w_low;

    // The update stage moves when the result register is free or being emptied.
    assign w_advance  = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_advance;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lockout    <= LOCKOUT_RST;
            r_long_press <= LONG_PRESS_RST;
            r_debounce   <= DEBOUNCE_RST;
            r_min_record <= MIN_RECORD_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_LOCKOUT:    r_lockout    <= i_cfg_data[15:0];
                CFG_LONG_PRESS: r_long_press <= i_cfg_data[15:0];
                CFG_DEBOUNCE:   r_debounce   <= i_cfg_data[9:0];
                CFG_MIN_RECORD: r_min_record <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_in_cmd      <= t_cmd'(i_command);
            r_in_now      <= i_now_ms;
            r_in_rst_btn  <= i_reset_pressed;
            r_in_mode_btn <= i_mode_pressed;
            r_in_stored   <= i_stored_best;
        end
    end

    // Next state of the timer for the transaction in the input register.
    always_comb begin
        logic [31:0] v_hold;
        logic [31:0] v_gap;
        n_phase       = r_phase;
        n_tick        = r_tick;
        n_tick_dig    = r_tick_dig;
        n_captured    = r_captured;
        n_cap_dig     = r_cap_dig;
        n_last_trig   = r_last_trig;
        n_best        = r_best;
        n_last_seen   = r_last_seen;
        n_rec_checked = r_rec_checked;
        n_rst_hold    = r_rst_hold;
        n_rst_handled = r_rst_handled;
        n_mode_was    = r_mode_was;
        n_mode_hold   = r_mode_hold;
        n_fine        = r_fine;
        w_save        = 1'b0;
        w_save_val    = '0;
        v_hold        = r_rst_hold;
        v_gap         = r_in_now - r_last_trig;
        case (r_in_cmd)
            CMD_TICK: begin
                n_tick     = r_tick + 32'd1;
                n_tick_dig = (r_tick == '1) ? '0 : digits_inc(r_tick_dig);
            end
            CMD_GATE: begin
                if (v_gap > {16'd0, r_lockout}) begin
                    n_last_trig = r_in_now;
                    if (r_phase == PH_RUN) begin
                        n_captured = r_tick;
                        n_cap_dig  = r_tick_dig;
                        n_phase    = PH_DONE;
                    end else begin
                        n_tick     = '0;
                        n_tick_dig = '0;
                        n_phase    = PH_RUN;
                    end
                end
            end
            CMD_LOAD: begin
                n_best = (r_in_stored == EMPTY_STORE) ? '0 : r_in_stored;
            end
            CMD_POLL: begin
                // Reset button: long press clears the best time, short press the timer.
                if (r_in_rst_btn) begin
                    if (r_rst_hold == '0) begin
                        v_hold = r_in_now;
                    end
                    v_gap      = r_in_now - v_hold;
                    n_rst_hold = v_hold;
                    if (v_gap > {16'd0, r_long_press} && !r_rst_handled) begin
                        n_best        = '0;
                        w_save        = 1'b1;
                        w_save_val    = '0;
                        n_rst_handled = 1'b1;
                    end
                end else if (r_rst_hold != '0) begin
                    v_gap = r_in_now - r_rst_hold;
                    if (!r_rst_handled && v_gap < {16'd0, r_long_press}) begin
                        n_phase    = PH_IDLE;
                        n_captured = '0;
                        n_cap_dig  = '0;
                        n_tick     = '0;
                        n_tick_dig = '0;
                    end
                    n_rst_hold    = '0;
                    n_rst_handled = 1'b0;
                end
                // Mode button: a long enough press toggles the digit format on release.
                if (r_in_mode_btn && !r_mode_was) begin
                    n_mode_hold = r_in_now;
                end else if (!r_in_mode_btn && r_mode_was) begin
                    if (r_mode_hold != '0 && (r_in_now - r_mode_hold) > {22'd0, r_debounce}) begin
                        n_fine = !r_fine;
                    end
                    n_mode_hold = '0;
                end
                n_mode_was = r_in_mode_btn;
                // Record check, once per new capture of a finished lap.
                if (n_phase == PH_DONE) begin
                    if (n_captured != r_last_seen) begin
                        n_rec_checked = 1'b0;
                        n_last_seen   = n_captured;
                    end
                    if (!n_rec_checked) begin
                        if (n_captured > r_min_record &&
                            (n_best == '0 || n_captured < n_best)) begin
                            n_best     = n_captured;
                            w_save     = 1'b1;
                            w_save_val = n_captured;
                        end
                        n_rec_checked = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Display digits of the value shown after the update.
    always_comb begin
        case (n_phase)
            PH_RUN: begin
                w_shown     = n_tick_dig;
                w_run_state = RUN_RUNNING;
            end
            PH_DONE: begin
                w_shown     = n_cap_dig;
                w_run_state = RUN_FINISHED;
            end
            default: begin
                w_shown     = '0;
                w_run_state = RUN_IDLE;
            end
        endcase
        if (n_fine) begin
            w_high   = fine_high(w_shown);
            w_middle = w_shown.msecs;
            w_low    = {3'd0, w_shown.units};
        end else begin
            w_high   = w_shown.mins_mod;
            w_middle = {4'd0, w_shown.secs};
            w_low    = w_shown.msecs;
        end
    end

    // Timer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tick        <= '0;
            r_tick_dig    <= '0;
            r_captured    <= '0;
            r_cap_dig     <= '0;
            r_last_trig   <= '0;
            r_best        <= '0;
            r_last_seen   <= '0;
            r_rec_checked <= 1'b0;
            r_rst_hold    <= '0;
            r_rst_handled <= 1'b0;
            r_mode_was    <= 1'b0;
            r_mode_hold   <= '0;
            r_fine        <= 1'b0;
        end else if (r_in_valid && w_advance) begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_tick_dig    <= n_tick_dig;
            r_captured    <= n_captured;
            r_cap_dig     <= n_cap_dig;
            r_last_trig   <= n_last_trig;
            r_best        <= n_best;
            r_last_seen   <= n_last_seen;
            r_rec_checked <= n_rec_checked;
            r_rst_hold    <= n_rst_hold;
            r_rst_handled <= n_rst_handled;
            r_mode_was    <= n_mode_was;
            r_mode_hold   <= n_mode_hold;
            r_fine        <= n_fine;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
        if (r_in_valid && w_advance) begin
            r_out_run_state <= w_run_state;
            r_out_fine      <= n_fine;
            r_out_high      <= w_high;
            r_out_middle    <= w_middle;
            r_out_low       <= w_low;
            r_out_best      <= n_best;
            r_out_save      <= w_save;
            r_out_save_val  <= w_save_val;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_run_state      = r_out_run_state;
    assign o_fine_mode      = r_out_fine;
    assign o_digits_high    = r_out_high;
    assign o_digits_middle  = r_out_middle;
    assign o_digits_low     = r_out_low;
    assign o_best_ticks_out = r_out_best;
    assign o_save_request   = r_out_save;
    assign o_save_value     = r_out_save_val;

endmodule
